### sv/sch_pkg.sv
// ============================================================================
// sch_pkg
// Shared constants for the sorted chained hash table: field widths, command
// and status codes, and default sizes.
// ============================================================================
package sch_pkg;

    localparam int KEY_W    = 31;
    localparam int STATUS_W = 2;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_BUCKETS   = 10;
    localparam int DEFAULT_POOL_SIZE = 256;

    // Key bits folded into the bucket remainder per cycle.
    localparam int DIGIT_BITS = 4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

endpackage

### sv/sorted_chained_hash_table.sv
// ============================================================================
// sorted_chained_hash_table
// Hash table with separate chaining, chains kept in ascending key order,
// nodes taken from a fixed pool by a bump allocator.
// ============================================================================
// Requests are handled one at a time. A request is accepted in S_IDLE,
// then passes through the bucket index unit (key modulo BUCKETS, four key
// bits per cycle) in S_HASH, reads the bucket head in S_HEAD, visits the
// chain nodes in the node memory in S_NODE, on an insert writes the new
// node in S_LINK_NEW and relinks its predecessor, if any, in S_LINK_PREV,
// and loads the response register in S_RESP. The chain walk through the
// node memory port takes longer on a longer chain. A search stops at the
// first node whose key is not below the searched key. After reset the
// block clears the bucket heads and holds req_ready low meanwhile. A
// finished response waits in its own register, so the next request may be
// accepted before the response is taken.
module sorted_chained_hash_table
    import sch_pkg::*;
#(
    parameter int BUCKETS   = DEFAULT_BUCKETS,
    parameter int POOL_SIZE = DEFAULT_POOL_SIZE
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                command,
    input  logic [KEY_W-1:0]    key,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [STATUS_W-1:0] status,
    output logic [KEY_W-1:0]    found_key
);

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int PTR_W = $clog2(POOL_SIZE);
    localparam int CNT_W = $clog2(POOL_SIZE + 1);

    typedef struct packed {
        logic             valid;
        logic [PTR_W-1:0] ptr;
    } link_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        link_t            next;
    } node_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_NODE,
        S_LINK_NEW,
        S_LINK_PREV,
        S_RESP
    } state_t;

    state_t               state_reg, state_next;
    logic                 cmd_reg, cmd_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [PTR_W-1:0]     cur_reg, cur_next;
    link_t                head_reg, head_next;
    logic                 have_prev_reg, have_prev_next;
    logic [PTR_W-1:0]     prev_ptr_reg, prev_ptr_next;
    logic [KEY_W-1:0]     prev_key_reg, prev_key_next;
    link_t                prev_link_reg, prev_link_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [KEY_W-1:0]     res_found_reg, res_found_next;
    logic [CNT_W-1:0]     nodes_used_reg, nodes_used_next;
    logic [BKT_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [KEY_W-1:0]     found_key_reg, found_key_next;

    logic                 req_accept;
    logic                 bkt_done;
    logic [BKT_W-1:0]     bucket;
    logic                 pool_full;
    logic [PTR_W-1:0]     new_ptr;

    logic                 head_we;
    logic [BKT_W-1:0]     head_waddr;
    link_t                head_wdata;
    logic [BKT_W-1:0]     head_raddr;
    link_t                head_rdata;

    logic                 node_we;
    logic [PTR_W-1:0]     node_waddr;
    node_t                node_wdata;
    logic [PTR_W-1:0]     node_raddr;
    node_t                node_rdata;

    assign req_ready  = (state_reg == S_IDLE);
    assign req_accept = req_valid && req_ready;
    assign pool_full  = (nodes_used_reg == CNT_W'(POOL_SIZE));
    assign new_ptr    = nodes_used_reg[PTR_W-1:0];

    sch_bucket #(
        .BUCKETS (BUCKETS)
    ) u_bucket (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (req_accept),
        .key    (key),
        .done   (bkt_done),
        .bucket (bucket)
    );

    sch_ram #(
        .WIDTH ($bits(link_t)),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    sch_ram #(
        .WIDTH ($bits(node_t)),
        .DEPTH (POOL_SIZE)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        cur_next        = cur_reg;
        head_next       = head_reg;
        have_prev_next  = have_prev_reg;
        prev_ptr_next   = prev_ptr_reg;
        prev_key_next   = prev_key_reg;
        prev_link_next  = prev_link_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        nodes_used_next = nodes_used_reg;
        clr_cnt_next    = clr_cnt_reg;
        rsp_valid_next  = rsp_valid_reg;
        status_next     = status_reg;
        found_key_next  = found_key_reg;

        head_we    = 1'b0;
        head_waddr = bucket;
        head_wdata = '0;
        head_raddr = bucket;
        node_we    = 1'b0;
        node_waddr = new_ptr;
        node_wdata = '0;
        node_raddr = node_rdata.next.ptr;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == BKT_W'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_accept)
                begin
                    cmd_next       = command;
                    key_next       = key;
                    have_prev_next = 1'b0;
                    state_next     = S_HASH;
                end
            end

            S_HASH:
            begin
                if (bkt_done)
                begin
                    state_next = S_HEAD;
                end
            end

            S_HEAD:
            begin
                head_next      = head_rdata;
                res_found_next = '0;
                node_raddr     = head_rdata.ptr;
                cur_next       = head_rdata.ptr;
                if (cmd_reg == CMD_INSERT && pool_full)
                begin
                    res_status_next = STAT_FULL;
                    state_next      = S_RESP;
                end
                else if (head_rdata.valid)
                begin
                    state_next = S_NODE;
                end
                else if (cmd_reg == CMD_SEARCH)
                begin
                    res_status_next = STAT_MISS;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_LINK_NEW;
                end
            end

            S_NODE:
            begin
                cur_next = node_rdata.next.ptr;
                if (cmd_reg == CMD_SEARCH)
                begin
                    if (node_rdata.key == key_reg)
                    begin
                        res_status_next = STAT_OK;
                        res_found_next  = key_reg;
                        state_next      = S_RESP;
                    end
                    else if (node_rdata.key > key_reg || !node_rdata.next.valid)
                    begin
                        res_status_next = STAT_MISS;
                        state_next      = S_RESP;
                    end
                end
                else if (node_rdata.key < key_reg)
                begin
                    // This node stays in front of the new one.
                    have_prev_next = 1'b1;
                    prev_ptr_next  = cur_reg;
                    prev_key_next  = node_rdata.key;
                    prev_link_next = node_rdata.next;
                    if (!node_rdata.next.valid)
                    begin
                        state_next = S_LINK_NEW;
                    end
                end
                else
                begin
                    state_next = S_LINK_NEW;
                end
            end

            S_LINK_NEW:
            begin
                node_we         = 1'b1;
                node_waddr      = new_ptr;
                node_wdata.key  = key_reg;
                node_wdata.next = have_prev_reg ? prev_link_reg : head_reg;
                res_status_next = STAT_OK;
                if (have_prev_reg)
                begin
                    state_next = S_LINK_PREV;
                end
                else
                begin
                    head_we          = 1'b1;
                    head_wdata.valid = 1'b1;
                    head_wdata.ptr   = new_ptr;
                    nodes_used_next  = nodes_used_reg + 1'b1;
                    state_next       = S_RESP;
                end
            end

            S_LINK_PREV:
            begin
                node_we               = 1'b1;
                node_waddr            = prev_ptr_reg;
                node_wdata.key        = prev_key_reg;
                node_wdata.next.valid = 1'b1;
                node_wdata.next.ptr   = new_ptr;
                nodes_used_next       = nodes_used_reg + 1'b1;
                state_next            = S_RESP;
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    found_key_next = res_found_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cmd_reg        <= CMD_INSERT;
            key_reg        <= '0;
            cur_reg        <= '0;
            head_reg       <= '0;
            have_prev_reg  <= 1'b0;
            prev_ptr_reg   <= '0;
            prev_key_reg   <= '0;
            prev_link_reg  <= '0;
            res_status_reg <= STAT_OK;
            res_found_reg  <= '0;
            nodes_used_reg <= '0;
            clr_cnt_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
            status_reg     <= STAT_OK;
            found_key_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            key_reg        <= key_next;
            cur_reg        <= cur_next;
            head_reg       <= head_next;
            have_prev_reg  <= have_prev_next;
            prev_ptr_reg   <= prev_ptr_next;
            prev_key_reg   <= prev_key_next;
            prev_link_reg  <= prev_link_next;
            res_status_reg <= res_status_next;
            res_found_reg  <= res_found_next;
            nodes_used_reg <= nodes_used_next;
            clr_cnt_reg    <= clr_cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
            status_reg     <= status_next;
            found_key_reg  <= found_key_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign found_key = found_key_reg;

    // The allocator never hands out more nodes than the pool holds.
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nodes_used_reg <= CNT_W'(POOL_SIZE))
        else $error("node count exceeds pool size");

    // The node count only ever grows by one, and only while linking an insert.
    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        nodes_used_reg != $past(nodes_used_reg) |->
            nodes_used_reg == $past(nodes_used_reg) + 1'b1 &&
            ($past(state_reg) == S_LINK_NEW || $past(state_reg) == S_LINK_PREV))
        else $error("unexpected change of node count");

    // A full report is given only when the pool really is exhausted.
    a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) && status_reg == STAT_FULL |->
            nodes_used_reg == CNT_W'(POOL_SIZE))
        else $error("pool full reported with free nodes");

    // Only a hit carries a key back.
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && status_reg != STAT_OK |-> found_key_reg == '0)
        else $error("found key set on a miss or refusal");

    // Relinking an existing node always targets an allocated node.
    a_prev_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LINK_PREV |-> CNT_W'(prev_ptr_reg) < nodes_used_reg)
        else $error("relink of an unallocated node");

endmodule

### sv/sch_ram.sv
// ============================================================================
// sch_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ============================================================================
module sch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/sch_bucket.sv
// ============================================================================
// sch_bucket
// Bucket index unit: reduces a key modulo BUCKETS by restoring reduction,
// DIGIT_BITS key bits per cycle, most significant bits first.
// ============================================================================
module sch_bucket
    import sch_pkg::*;
#(
    parameter int BUCKETS = DEFAULT_BUCKETS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [KEY_W-1:0]           key,
    output logic                       done,
    output logic [$clog2(BUCKETS)-1:0] bucket
);

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int WIDE_W = BKT_W + 1;
    localparam int DIGITS = (KEY_W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int MOD_W  = DIGITS * DIGIT_BITS;
    localparam int CNT_W  = $clog2(DIGITS);

    logic [MOD_W-1:0] shift_reg;
    logic [BKT_W-1:0] rem_reg;
    logic [BKT_W-1:0] rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // Each step doubles the remainder, brings in one key bit, and subtracts
    // the bucket count once if the value reached it.
    always_comb
    begin
        logic [WIDE_W-1:0] wide_v;
        logic [BKT_W-1:0]  rem_v;
        rem_v = rem_reg;
        for (int i = 0; i < DIGIT_BITS; i++)
        begin
            wide_v = {rem_v, shift_reg[MOD_W-1-i]};
            if (wide_v >= WIDE_W'(BUCKETS))
            begin
                wide_v = wide_v - WIDE_W'(BUCKETS);
            end
            rem_v = wide_v[BKT_W-1:0];
        end
        rem_next = rem_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (start)
        begin
            shift_reg <= MOD_W'(key);
            rem_reg   <= '0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg << DIGIT_BITS;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIGITS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done   = done_reg;
    assign bucket = rem_reg;

endmodule

### tb/sch_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// sch_checker
// Watches the request and response channels of the sorted chained hash
// table. It keeps its own copy of the buckets and the node pool, works out
// the response to every accepted request, and compares the responses in
// order.
// ============================================================================
module sch_checker
    import sch_pkg::*;
#(
    parameter int BUCKETS   = DEFAULT_BUCKETS,
    parameter int POOL_SIZE = DEFAULT_POOL_SIZE
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  logic                command,
    input  logic [KEY_W-1:0]    key,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  logic [STATUS_W-1:0] status,
    input  logic [KEY_W-1:0]    found_key,
    output int                  errors,
    output int                  pending,
    output int                  hits,
    output int                  refused
);

    localparam int NO_NODE = -1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    found_key;
    } table_rsp_t;

    table_rsp_t       rsp_due[$];
    logic [KEY_W-1:0] slot_key  [POOL_SIZE];
    int               slot_next [POOL_SIZE];
    int               chain_head[BUCKETS];
    int               slots_taken;
    int               n_err;
    int               n_hit;
    int               n_full;

    // Applies one request to the shadow table and returns its response.
    function automatic table_rsp_t lookup_or_link(input logic cmd, input logic [KEY_W-1:0] k);
        table_rsp_t r;
        int         b;
        int         cur;
        int         prv;
        int         n;
        b           = int'({1'b0, k} % BUCKETS);
        r.found_key = '0;
        if (cmd == CMD_INSERT)
        begin
            if (slots_taken >= POOL_SIZE)
            begin
                r.status = STAT_FULL;
            end
            else
            begin
                n           = slots_taken;
                slots_taken = slots_taken + 1;
                slot_key[n] = k;
                prv         = NO_NODE;
                cur         = chain_head[b];
                // An equal key stops the walk, so the new node lands in front of it.
                while (cur != NO_NODE && slot_key[cur] < k)
                begin
                    prv = cur;
                    cur = slot_next[cur];
                end
                slot_next[n] = cur;
                if (prv == NO_NODE)
                    chain_head[b] = n;
                else
                    slot_next[prv] = n;
                r.status = STAT_OK;
            end
        end
        else
        begin
            r.status = STAT_MISS;
            cur      = chain_head[b];
            while (cur != NO_NODE && r.status == STAT_MISS)
            begin
                if (slot_key[cur] == k)
                begin
                    r.status    = STAT_OK;
                    r.found_key = k;
                end
                cur = slot_next[cur];
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        table_rsp_t want;
        table_rsp_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKETS; i++)
                chain_head[i] = NO_NODE;
            slots_taken = 0;
            rsp_due.delete();
            n_err  = 0;
            n_hit  = 0;
            n_full = 0;
        end
        else
        begin
            // Responses are checked before this edge's request is queued, since a
            // request can never be answered at the edge that accepts it.
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("response with no request outstanding: status %0d found_key %0d",
                           status, found_key);
                    n_err = n_err + 1;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, status);
                        n_err = n_err + 1;
                    end
                    if (found_key !== want.found_key)
                    begin
                        $error("found_key mismatch: expected %0d, actual %0d",
                               want.found_key, found_key);
                        n_err = n_err + 1;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                got = lookup_or_link(command, key);
                if (command == CMD_SEARCH && got.status == STAT_OK)
                    n_hit = n_hit + 1;
                if (got.status == STAT_FULL)
                    n_full = n_full + 1;
                rsp_due.push_back(got);
            end
        end
        errors  <= n_err;
        pending <= rsp_due.size();
        hits    <= n_hit;
        refused <= n_full;
    end

endmodule

### tb/sorted_chained_hash_table_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// sorted_chained_hash_table_tb
// Drives insert and search requests into the sorted chained hash table: a
// directed set of edge keys and duplicates, then a long random mix that fills
// the node pool, with random gaps on both channels and one long response
// stall. The checker beside the block predicts and compares every response.
// ============================================================================
module sorted_chained_hash_table_tb;
    import sch_pkg::*;

    localparam int BUCKETS   = DEFAULT_BUCKETS;
    localparam int POOL_SIZE = DEFAULT_POOL_SIZE;
    localparam int N_RANDOM  = 730;
    localparam int HOLD_AT   = 2000;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN_MAX = 200000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic                command = CMD_INSERT;
    logic [KEY_W-1:0]    key = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    found_key;

    int errors;
    int pending;
    int hits;
    int refused;
    int n_insert;
    int n_search;

    logic [KEY_W-1:0] inserted_keys[$];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    sorted_chained_hash_table #(
        .BUCKETS   (BUCKETS),
        .POOL_SIZE (POOL_SIZE)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .command   (command),
        .key       (key),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .found_key (found_key)
    );

    sch_checker #(
        .BUCKETS   (BUCKETS),
        .POOL_SIZE (POOL_SIZE)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .command   (command),
        .key       (key),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .found_key (found_key),
        .errors    (errors),
        .pending   (pending),
        .hits      (hits),
        .refused   (refused)
    );

    // Offers one request after a random gap and returns at the edge that takes it.
    // Valid is only lowered when a gap follows, so back-to-back requests keep it high.
    task automatic offer(input logic cmd, input logic [KEY_W-1:0] k);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            gap = 0;
        else if (pick < 88)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        command   <= cmd;
        key       <= k;
        do
            @(posedge clk);
        while (!req_ready);
        if (cmd == CMD_INSERT)
        begin
            n_insert = n_insert + 1;
            inserted_keys.push_back(k);
        end
        else
        begin
            n_search = n_search + 1;
        end
    endtask

    // Response side: random runs of ready and stall, plus one long hold-off that
    // lets the block fill up while requests keep coming.
    initial
    begin
        int pick;
        int run;
        int cyc;
        bit held;
        cyc  = 0;
        held = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && cyc >= HOLD_AT)
            begin
                held = 1'b1;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                cyc = cyc + LONG_HOLD;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    rsp_ready <= 1'b1;
                    run = $urandom_range(1, 40);
                end
                else if (pick < 95)
                begin
                    rsp_ready <= 1'b0;
                    run = $urandom_range(1, 4);
                end
                else
                begin
                    rsp_ready <= 1'b0;
                    run = $urandom_range(10, 60);
                end
                repeat (run) @(posedge clk);
                cyc = cyc + run;
            end
        end
    end

    initial
    begin
        #15_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int               pick;
        int               waited;
        logic             cmd;
        logic [KEY_W-1:0] k;
        n_insert = 0;
        n_search = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: empty buckets, the key extremes, sorted placement at the
        // head, middle and tail, a duplicate key, and misses around a chain.
        offer(CMD_SEARCH, KEY_W'(5));
        offer(CMD_INSERT, KEY_W'(0));
        offer(CMD_INSERT, {KEY_W{1'b1}});
        offer(CMD_SEARCH, {KEY_W{1'b1}});
        offer(CMD_SEARCH, KEY_W'(0));
        offer(CMD_INSERT, KEY_W'(20));
        offer(CMD_INSERT, KEY_W'(10));
        offer(CMD_INSERT, KEY_W'(30));
        offer(CMD_INSERT, KEY_W'(10));
        offer(CMD_SEARCH, KEY_W'(10));
        offer(CMD_SEARCH, KEY_W'(30));
        offer(CMD_SEARCH, KEY_W'(40));
        offer(CMD_SEARCH, KEY_W'(1));
        offer(CMD_SEARCH, KEY_W'(15));
        offer(CMD_INSERT, {KEY_W{1'b1}} - KEY_W'(10));
        offer(CMD_SEARCH, {KEY_W{1'b1}} - KEY_W'(10));
        offer(CMD_INSERT, KEY_W'(31'h2AAA_AAAA));
        offer(CMD_INSERT, KEY_W'(31'h5555_5555));
        offer(CMD_SEARCH, KEY_W'(31'h2AAA_AAAA));
        offer(CMD_SEARCH, KEY_W'(31'h5555_5554));

        // Random part: mostly small keys so chains grow long and duplicates
        // are common; the pool runs out part way through.
        for (int i = 0; i < N_RANDOM; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                cmd  = CMD_INSERT;
                pick = $urandom_range(0, 99);
                if (pick < 50 || inserted_keys.size() == 0)
                    k = KEY_W'($urandom_range(0, 299));
                else if (pick < 75)
                    k = KEY_W'($urandom);
                else if (pick < 90)
                    k = {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 50));
                else
                    k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
            end
            else
            begin
                cmd  = CMD_SEARCH;
                pick = $urandom_range(0, 99);
                if (pick < 55 && inserted_keys.size() != 0)
                    k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
                else if (pick < 80)
                    k = KEY_W'($urandom_range(0, 299));
                else
                    k = KEY_W'($urandom);
            end
            offer(cmd, k);
        end
        req_valid <= 1'b0;

        waited = 0;
        do
        begin
            @(posedge clk);
            waited = waited + 1;
        end
        while (pending != 0 && waited < DRAIN_MAX);
        repeat (40) @(posedge clk);

        $display("Ran %0d inserts and %0d searches: %0d search hits, %0d inserts refused on a full pool.",
                 n_insert, n_search, hits, refused);
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
